// File: hw/rtl/mipp_pkg.sv
// Package for the multichannel incremental PI / PWM regulator.
// Holds widths, register codes, reset values and the state memory entry type.
// No dependencies.
package mipp_pkg;

  // Sizing
  localparam int CHANNELS   = 6;
  localparam int DUTY_FULL  = 100;
  localparam int CH_W       = 3;
  localparam int SPD_W      = 16;
  localparam int ERR_W      = 19;
  localparam int GAIN_W     = 16;
  localparam int ACC_W      = 48;
  localparam int DUTY_W     = 7;
  localparam int MASK_W     = 6;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  // Derived widths
  localparam int PROD_W = GAIN_W + 1 + ERR_W;           // unsigned gain times signed error
  localparam int SUM_W  = ACC_W + 2;                    // accumulator plus two products
  localparam int Q_W    = $clog2(DUTY_FULL + 1);        // quotient bits before clamp
  localparam int N_W    = ACC_W - 1 + Q_W;              // positive acc times DUTY_FULL
  localparam int DEN_W  = GAIN_W + 16;                  // tension_max in Q16
  localparam int CNT_W  = $clog2(Q_W + 1);

  // Accumulator limits
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_GAIN_CURRENT  = 2'd0,
    REG_GAIN_PREVIOUS = 2'd1,
    REG_TENSION_MAX   = 2'd2,
    REG_COUPLED_MASK  = 2'd3
  } mipp_reg_t;

  localparam logic [GAIN_W-1:0] GAIN_CURRENT_RST  = 16'd4806;
  localparam logic [GAIN_W-1:0] GAIN_PREVIOUS_RST = 16'd4502;
  localparam logic [GAIN_W-1:0] TENSION_MAX_RST   = 16'd12;
  localparam logic [MASK_W-1:0] COUPLED_MASK_RST  = 6'd30;

  // One entry of the per-channel state memory
  typedef struct packed {
    logic [ACC_W-1:0] last_output;
    logic [ERR_W-1:0] last_error;
  } mipp_entry_t;

endpackage

// File: hw/rtl/multichannel_incremental_pi_pwm.sv
// Each item passes S_MEM, S_MUL and S_SCALE, then the divider in S_DIV, then S_OUT loads
// the output register; an overflowing duty leaves S_DIV at its first step, and a channel past
// the last goes straight to S_OUT. One item at a time; the restoring divider gives one quotient bit per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): registers return to defaults, all channel states read as zero.
// Per-channel state lives in a 6-entry synchronous memory with a valid bit per entry.
module multichannel_incremental_pi_pwm (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mipp_pkg::CH_W-1:0]         channel,
  input  logic signed [mipp_pkg::SPD_W-1:0] own_speed,
  input  logic signed [mipp_pkg::SPD_W-1:0] partner_speed,
  input  logic signed [mipp_pkg::SPD_W-1:0] target_speed,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mipp_pkg::CH_W-1:0]         out_channel,
  output logic [mipp_pkg::DUTY_W-1:0]       duty,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mipp_pkg::APB_AW-1:0]       paddr,
  input  logic [mipp_pkg::APB_DW-1:0]       pwdata,
  output logic [mipp_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEM,
    S_MUL,
    S_SCALE,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [mipp_pkg::GAIN_W-1:0] gain_current;
  logic [mipp_pkg::GAIN_W-1:0] gain_previous;
  logic [mipp_pkg::GAIN_W-1:0] tension_max;
  logic [mipp_pkg::MASK_W-1:0] coupled_mask;

  // Job registers
  logic [mipp_pkg::CH_W-1:0]          job_ch;
  logic signed [mipp_pkg::ERR_W-1:0]  job_err;
  logic signed [mipp_pkg::PROD_W-1:0] prod_cur;
  logic signed [mipp_pkg::PROD_W-1:0] prod_prev;
  logic signed [mipp_pkg::ACC_W-1:0]  last_out;
  logic signed [mipp_pkg::ACC_W-1:0]  acc;
  logic [mipp_pkg::N_W-1:0]           rem;
  logic [mipp_pkg::DEN_W-1:0]         den;
  logic [mipp_pkg::CNT_W-1:0]         div_cnt;
  logic [mipp_pkg::Q_W-1:0]           quo;
  logic                               ovf;

  // State memory and its valid bits
  mipp_pkg::mipp_entry_t mem [mipp_pkg::CHANNELS];
  mipp_pkg::mipp_entry_t rd_data;
  mipp_pkg::mipp_entry_t wr_data;
  logic                  rd_vld;
  logic [mipp_pkg::CHANNELS-1:0] vld;
  logic                  mem_re;
  logic                  mem_we;

  // Combinational helpers
  logic                               in_xfer;
  logic                               out_xfer;
  logic                               ch_ok;
  logic signed [mipp_pkg::ERR_W-1:0]  own_x;
  logic signed [mipp_pkg::ERR_W-1:0]  partner_x;
  logic signed [mipp_pkg::ERR_W-1:0]  target_x;
  logic signed [mipp_pkg::ERR_W-1:0]  err_new;
  logic signed [mipp_pkg::ACC_W-1:0]  mem_out;
  logic signed [mipp_pkg::ERR_W-1:0]  mem_err;
  logic signed [mipp_pkg::SUM_W-1:0]  sum;
  logic signed [mipp_pkg::ACC_W-1:0]  acc_sat;
  logic [mipp_pkg::N_W-1:0]           scaled;
  logic [mipp_pkg::N_W-1:0]           shifted;
  logic                               rem_ge;
  logic [mipp_pkg::DUTY_W-1:0]        result_duty;
  logic                               cfg_wr;
  mipp_pkg::mipp_reg_t                cfg_idx;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign ch_ok    = (channel < mipp_pkg::CH_W'(mipp_pkg::CHANNELS));

  // Speed error, plain or synchronizing form
  always_comb begin
    own_x     = mipp_pkg::ERR_W'(own_speed);
    partner_x = mipp_pkg::ERR_W'(partner_speed);
    target_x  = mipp_pkg::ERR_W'(target_speed);
    if (coupled_mask[channel[$clog2(mipp_pkg::MASK_W)-1:0]] && ch_ok) begin
      err_new = target_x - (own_x <<< 1) + partner_x;
    end else begin
      err_new = target_x - own_x;
    end
  end

  // Stored state, an entry never written reads as zero
  assign mem_out = rd_vld ? $signed(rd_data.last_output) : '0;
  assign mem_err = rd_vld ? $signed(rd_data.last_error) : '0;

  // Accumulate and saturate
  always_comb begin
    sum = mipp_pkg::SUM_W'(last_out) + mipp_pkg::SUM_W'(prod_cur)
        - mipp_pkg::SUM_W'(prod_prev);
    if (sum > mipp_pkg::SUM_W'($signed(mipp_pkg::ACC_MAX))) begin
      acc_sat = $signed(mipp_pkg::ACC_MAX);
    end else if (sum < mipp_pkg::SUM_W'($signed(mipp_pkg::ACC_MIN))) begin
      acc_sat = $signed(mipp_pkg::ACC_MIN);
    end else begin
      acc_sat = $signed(sum[mipp_pkg::ACC_W-1:0]);
    end
  end

  assign wr_data.last_output = acc_sat;
  assign wr_data.last_error  = job_err;
  assign mem_we = (state == S_MUL);
  assign mem_re = in_xfer && ch_ok;

  // Positive output times the full-duty count, the dividend of the duty
  always_comb begin
    if (!acc[mipp_pkg::ACC_W-1] && (acc != '0)) begin
      scaled = mipp_pkg::N_W'(acc[mipp_pkg::ACC_W-2:0]) * mipp_pkg::N_W'(mipp_pkg::DUTY_FULL);
    end else begin
      scaled = '0;
    end
  end

  // Restoring divider step
  assign shifted = mipp_pkg::N_W'(den) << div_cnt;
  assign rem_ge  = (rem >= shifted);

  // Clamp of the quotient
  always_comb begin
    if (ovf || (quo > mipp_pkg::Q_W'(mipp_pkg::DUTY_FULL))) begin
      result_duty = mipp_pkg::DUTY_W'(mipp_pkg::DUTY_FULL);
    end else begin
      result_duty = mipp_pkg::DUTY_W'(quo);
    end
  end

  // State memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[job_ch] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[channel];
    end
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      ovf       <= 1'b0;
      quo       <= '0;
      div_cnt   <= '0;
    end else begin
      // S_OUT reloads the output register itself on a transfer
      if (out_xfer && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            job_ch  <= channel;
            job_err <= err_new;
            rd_vld  <= ch_ok && vld[channel];
            quo     <= '0;
            ovf     <= 1'b0;
            state   <= ch_ok ? S_MEM : S_OUT;
          end
        end
        S_MEM: begin
          prod_cur  <= $signed({1'b0, gain_current}) * job_err;
          prod_prev <= $signed({1'b0, gain_previous}) * mem_err;
          last_out  <= mem_out;
          state     <= S_MUL;
        end
        S_MUL: begin
          acc         <= acc_sat;
          vld[job_ch] <= 1'b1;
          state       <= S_SCALE;
        end
        S_SCALE: begin
          rem     <= scaled;
          den     <= (tension_max == '0) ? mipp_pkg::DEN_W'(1) << 16 : {tension_max, 16'h0000};
          div_cnt <= mipp_pkg::CNT_W'(mipp_pkg::Q_W);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == mipp_pkg::CNT_W'(mipp_pkg::Q_W)) begin
            // quotient too wide for the duty range
            if (rem_ge) begin
              ovf   <= 1'b1;
              state <= S_OUT;
            end else begin
              div_cnt <= div_cnt - 1'b1;
            end
          end else begin
            if (rem_ge) begin
              rem          <= rem - shifted;
              quo[div_cnt] <= 1'b1;
            end
            if (div_cnt == '0) begin
              state <= S_OUT;
            end else begin
              div_cnt <= div_cnt - 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            out_channel <= job_ch;
            duty        <= result_duty;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = mipp_pkg::mipp_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_current  <= mipp_pkg::GAIN_CURRENT_RST;
      gain_previous <= mipp_pkg::GAIN_PREVIOUS_RST;
      tension_max   <= mipp_pkg::TENSION_MAX_RST;
      coupled_mask  <= mipp_pkg::COUPLED_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mipp_pkg::REG_GAIN_CURRENT:  gain_current  <= pwdata[mipp_pkg::GAIN_W-1:0];
        mipp_pkg::REG_GAIN_PREVIOUS: gain_previous <= pwdata[mipp_pkg::GAIN_W-1:0];
        mipp_pkg::REG_TENSION_MAX:   tension_max   <= pwdata[mipp_pkg::GAIN_W-1:0];
        mipp_pkg::REG_COUPLED_MASK:  coupled_mask  <= pwdata[mipp_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mipp_pkg::REG_GAIN_CURRENT:  prdata = mipp_pkg::APB_DW'(gain_current);
      mipp_pkg::REG_GAIN_PREVIOUS: prdata = mipp_pkg::APB_DW'(gain_previous);
      mipp_pkg::REG_TENSION_MAX:   prdata = mipp_pkg::APB_DW'(tension_max);
      mipp_pkg::REG_COUPLED_MASK:  prdata = mipp_pkg::APB_DW'(coupled_mask);
      default:                     prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  // duty never leaves the PWM range
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty <= mipp_pkg::DUTY_W'(mipp_pkg::DUTY_FULL)))
    else $error("duty above PWM period");

  // one item in flight: an accepted transfer closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("input taken while busy");

  // state write-back only for an existing channel
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (job_ch < mipp_pkg::CH_W'(mipp_pkg::CHANNELS)))
    else $error("state write to missing channel");
`endif

endmodule
